@@ design/qrsg_pkg.sv @@
`timescale 1ns / 1ps

package qrsg_pkg;

    // configuration port
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 4;
    localparam int REG_IDX_WIDTH  = 2;

    localparam logic [REG_IDX_WIDTH-1:0] REG_RATIO_NUM  = 2'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_RATIO_DEN  = 2'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_THREAD     = 2'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_STOP_ZERO  = 2'd3;

    // field widths
    localparam int NUM_WIDTH      = 6;
    localparam int DEN_WIDTH      = 8;
    localparam int ACC_WIDTH      = 9;
    localparam int CMD_WIDTH      = 2;
    localparam int POS_OUT_WIDTH  = 32;

    // step burst cap per edge
    localparam int MAX_STEPS      = 63;
    localparam int STEP_CNT_WIDTH = 6;

    // commands
    localparam logic [CMD_WIDTH-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_ENABLE = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_ZERO   = 2'd2;

    // accumulator unit operations
    localparam logic ACC_OP_ADD = 1'b0;
    localparam logic ACC_OP_SUB = 1'b1;

    // quadrature transition codes
    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_FWD  = 2'd1;
    localparam logic [1:0] EDGE_REV  = 2'd2;
    localparam logic [1:0] EDGE_BAD  = 2'd3;

    // indexed by {old phase, new b, new a}
    localparam logic [1:0] EDGE_TABLE [16] = '{
        EDGE_NONE, EDGE_REV,  EDGE_FWD,  EDGE_BAD,
        EDGE_FWD,  EDGE_NONE, EDGE_BAD,  EDGE_REV,
        EDGE_REV,  EDGE_BAD,  EDGE_NONE, EDGE_FWD,
        EDGE_BAD,  EDGE_FWD,  EDGE_REV,  EDGE_NONE
    };

    typedef struct packed {
        logic [NUM_WIDTH-1:0] ratio_numerator;
        logic [DEN_WIDTH-1:0] ratio_denominator;
        logic                 thread_mode;
        logic                 stop_at_zero;
    } cfg_t;

endpackage

@@ design/qrsg_if.sv @@
`timescale 1ns / 1ps

interface qrsg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       phase_a;
    logic       phase_b;
    logic       enable_value;

    modport source (output valid, command, phase_a, phase_b, enable_value, input ready);
    modport sink   (input valid, command, phase_a, phase_b, enable_value, output ready);
endinterface

interface qrsg_out_if;
    logic               valid;
    logic               ready;
    logic               has_step;
    logic               step_direction;
    logic signed [31:0] leadscrew_position;
    logic signed [31:0] spindle_position;
    logic               enabled_now;
    logic               last;

    modport source (output valid, has_step, step_direction, leadscrew_position,
                    spindle_position, enabled_now, last, input ready);
    modport sink   (input valid, has_step, step_direction, leadscrew_position,
                    spindle_position, enabled_now, last, output ready);
endinterface

@@ design/quadrature_ratio_step_generator.sv @@
`timescale 1ns / 1ps

// Electronic gearbox: decodes spindle quadrature samples and turns counted
// edges into leadscrew step transactions through a ratio accumulator. Every
// input transaction yields at least one result transaction; the final one of
// each input carries last. A command, a sample without a counted edge, or an
// edge that produces no step yields one status result. A counted edge
// that produces N steps (1 to 63) first adds the numerator and then emits
// the steps one after another, because a single accumulator unit
// does the add, every denominator subtraction and the compare that decides
// whether another step follows. Input ready drops for the whole burst and
// whenever the output register holds a result that is not taken. Positions
// are kept at POSITION_WIDTH bits and reported sign-extended (or truncated)
// to 32 bits. Configuration is written through the APB port at byte
// addresses 0, 4, 8, 12 and must only change while the block is idle.
module quadrature_ratio_step_generator #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    qrsg_in_if.sink                              in_ch,
    qrsg_out_if.source                           out_ch,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [qrsg_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [qrsg_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [qrsg_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready
);
    import qrsg_pkg::*;

    cfg_t                      cfg;
    logic [POSITION_WIDTH-1:0] lead_pos;
    logic [POSITION_WIDTH-1:0] spin_pos;

    // register file
    qrsg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // decoder, accumulator sequencer and output register
    qrsg_seq #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_ch         (in_ch),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .out_has_step  (out_ch.has_step),
        .out_direction (out_ch.step_direction),
        .out_leadscrew (lead_pos),
        .out_spindle   (spin_pos),
        .out_enabled   (out_ch.enabled_now),
        .out_last      (out_ch.last)
    );

    // positions reported at the fixed output width
    generate
        if (POSITION_WIDTH >= POS_OUT_WIDTH)
        begin : g_pos_trunc
            assign out_ch.leadscrew_position = lead_pos[POS_OUT_WIDTH-1:0];
            assign out_ch.spindle_position   = spin_pos[POS_OUT_WIDTH-1:0];
        end
        else
        begin : g_pos_sext
            assign out_ch.leadscrew_position =
                {{(POS_OUT_WIDTH-POSITION_WIDTH){lead_pos[POSITION_WIDTH-1]}}, lead_pos};
            assign out_ch.spindle_position   =
                {{(POS_OUT_WIDTH-POSITION_WIDTH){spin_pos[POSITION_WIDTH-1]}}, spin_pos};
        end
    endgenerate

`ifndef NO_ASSERTIONS
    // an input transaction is taken only when the output register can load
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |-> (!out_ch.valid || out_ch.ready))
        else $error("input accepted while output register is blocked");

    // a status result always closes its input
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.has_step) |-> out_ch.last)
        else $error("status result without last");

    // no new input while a step burst is still open
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.last) |-> !in_ch.ready)
        else $error("input ready during a step burst");

    // a result not yet taken holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.last)))
        else $error("pending result dropped or changed");
`endif

endmodule

@@ design/qrsg_cfg.sv @@
`timescale 1ns / 1ps

module qrsg_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [qrsg_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [qrsg_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [qrsg_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready,
    output qrsg_pkg::cfg_t                       cfg
);
    import qrsg_pkg::*;

    logic [NUM_WIDTH-1:0]     num_reg;
    logic [DEN_WIDTH-1:0]     den_reg;
    logic                     thread_reg;
    logic                     stop_reg;
    logic [REG_IDX_WIDTH-1:0] reg_idx;
    logic                     wr_en;

    assign reg_idx = paddr[APB_ADDR_WIDTH-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg    <= NUM_WIDTH'(1);
            den_reg    <= DEN_WIDTH'(1);
            thread_reg <= 1'b1;
            stop_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_RATIO_NUM: num_reg    <= pwdata[NUM_WIDTH-1:0];
                REG_RATIO_DEN: den_reg    <= pwdata[DEN_WIDTH-1:0];
                REG_THREAD:    thread_reg <= pwdata[0];
                REG_STOP_ZERO: stop_reg   <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_RATIO_NUM: prdata = APB_DATA_WIDTH'(num_reg);
            REG_RATIO_DEN: prdata = APB_DATA_WIDTH'(den_reg);
            REG_THREAD:    prdata = APB_DATA_WIDTH'(thread_reg);
            REG_STOP_ZERO: prdata = APB_DATA_WIDTH'(stop_reg);
        endcase
    end

    assign cfg.ratio_numerator   = num_reg;
    assign cfg.ratio_denominator = den_reg;
    assign cfg.thread_mode       = thread_reg;
    assign cfg.stop_at_zero      = stop_reg;

endmodule

@@ design/qrsg_acc_unit.sv @@
`timescale 1ns / 1ps

// shared accumulator add / subtract with compare against the denominator
module qrsg_acc_unit (
    input  logic                            op,
    input  logic [qrsg_pkg::ACC_WIDTH-1:0]  acc,
    input  logic [qrsg_pkg::NUM_WIDTH-1:0]  num,
    input  logic [qrsg_pkg::DEN_WIDTH-1:0]  den,
    output logic [qrsg_pkg::ACC_WIDTH-1:0]  result,
    output logic                            ge
);
    import qrsg_pkg::*;

    assign result = (op == ACC_OP_SUB) ? acc - ACC_WIDTH'(den)
                                       : acc + ACC_WIDTH'(num);
    assign ge     = (result >= ACC_WIDTH'(den));

endmodule

@@ design/qrsg_seq.sv @@
`timescale 1ns / 1ps

module qrsg_seq #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  qrsg_pkg::cfg_t             cfg,
    qrsg_in_if.sink                    in_ch,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic                       out_has_step,
    output logic                       out_direction,
    output logic [POSITION_WIDTH-1:0]  out_leadscrew,
    output logic [POSITION_WIDTH-1:0]  out_spindle,
    output logic                       out_enabled,
    output logic                       out_last
);
    import qrsg_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                      state_reg, state_next;
    logic [1:0]                phase_reg, phase_next;
    logic                      dir_reg, dir_next;
    logic [ACC_WIDTH-1:0]      acc_reg, acc_next;
    logic [POSITION_WIDTH-1:0] lead_reg, lead_next;
    logic [POSITION_WIDTH-1:0] spin_reg, spin_next;
    logic                      en_reg, en_next;
    logic [STEP_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;

    logic                      has_step_reg, direction_reg, enabled_reg, last_reg;
    logic [POSITION_WIDTH-1:0] lead_out_reg, spin_out_reg;

    logic                      out_free;
    logic                      accept;
    logic                      emit;
    logic                      emit_step;
    logic                      emit_last;
    logic [1:0]                new_phase;
    logic [1:0]                edge_code;
    logic                      is_edge;
    logic                      edge_fwd;
    logic [DEN_WIDTH-1:0]      den_eff;
    logic                      unit_op;
    logic [ACC_WIDTH-1:0]      unit_result;
    logic                      unit_ge;
    logic [POSITION_WIDTH-1:0] lead_stepped;
    logic [POSITION_WIDTH-1:0] spin_stepped;
    logic                      burst_end;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = in_ch.valid && in_ch.ready;

    assign new_phase = {in_ch.phase_b, in_ch.phase_a};
    assign edge_code = EDGE_TABLE[{phase_reg, new_phase}];
    assign is_edge   = (edge_code == EDGE_FWD) || (edge_code == EDGE_REV);
    assign edge_fwd  = (edge_code == EDGE_FWD);

    // a zero denominator counts as one
    assign den_eff   = (cfg.ratio_denominator == '0) ? DEN_WIDTH'(1)
                                                     : cfg.ratio_denominator;
    assign unit_op   = (state_reg == ST_RUN) ? ACC_OP_SUB : ACC_OP_ADD;

    qrsg_acc_unit u_acc (
        .op     (unit_op),
        .acc    (acc_reg),
        .num    (cfg.ratio_numerator),
        .den    (den_eff),
        .result (unit_result),
        .ge     (unit_ge)
    );

    assign lead_stepped = dir_reg  ? lead_reg + POSITION_WIDTH'(1) : lead_reg - POSITION_WIDTH'(1);
    assign spin_stepped = edge_fwd ? spin_reg + POSITION_WIDTH'(1) : spin_reg - POSITION_WIDTH'(1);
    assign burst_end    = !unit_ge || (cnt_reg == STEP_CNT_WIDTH'(MAX_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        dir_next   = dir_reg;
        acc_next   = acc_reg;
        lead_next  = lead_reg;
        spin_next  = spin_reg;
        en_next    = en_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        emit_step  = 1'b0;
        emit_last  = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    emit = 1'b1;
                    unique case (in_ch.command)
                        CMD_SAMPLE:
                        begin
                            phase_next = new_phase;
                            if (is_edge)
                            begin
                                dir_next = edge_fwd;
                                if (en_reg)
                                begin
                                    acc_next = unit_result;
                                    // steps follow, one per cycle while the output register is free
                                    if (unit_ge)
                                    begin
                                        emit       = 1'b0;
                                        cnt_next   = '0;
                                        state_next = ST_RUN;
                                    end
                                end
                                else if (cfg.thread_mode)
                                begin
                                    spin_next = spin_stepped;
                                end
                            end
                        end
                        CMD_ENABLE:
                        begin
                            en_next = in_ch.enable_value;
                        end
                        CMD_ZERO:
                        begin
                            lead_next = '0;
                            spin_next = POSITION_WIDTH'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_step = 1'b1;
                    emit_last = burst_end;
                    acc_next  = unit_result;
                    lead_next = lead_stepped;
                    cnt_next  = cnt_reg + STEP_CNT_WIDTH'(1);
                    if (cfg.stop_at_zero && (lead_stepped == '0))
                    begin
                        en_next = 1'b0;
                    end
                    if (burst_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            dir_reg       <= 1'b0;
            acc_reg       <= '0;
            lead_reg      <= '0;
            spin_reg      <= POSITION_WIDTH'(1);
            en_reg        <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            dir_reg       <= dir_next;
            acc_reg       <= acc_next;
            lead_reg      <= lead_next;
            spin_reg      <= spin_next;
            en_reg        <= en_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            has_step_reg  <= emit_step;
            direction_reg <= dir_next;
            lead_out_reg  <= lead_next;
            spin_out_reg  <= spin_next;
            enabled_reg   <= en_next;
            last_reg      <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_has_step  = has_step_reg;
    assign out_direction = direction_reg;
    assign out_leadscrew = lead_out_reg;
    assign out_spindle   = spin_out_reg;
    assign out_enabled   = enabled_reg;
    assign out_last      = last_reg;

endmodule

@@ bench/qrsg_checker.sv @@
`timescale 1ns / 1ps

module qrsg_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    qrsg_in_if                                   cmd_ch,
    qrsg_out_if                                  result_ch,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [qrsg_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [qrsg_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output int                                   fail_count,
    output int                                   pending
);
    import qrsg_pkg::*;

    typedef struct packed {
        logic        has_step;
        logic        step_direction;
        logic [31:0] leadscrew_position;
        logic [31:0] spindle_position;
        logic        enabled_now;
        logic        last;
    } gear_result_t;

    gear_result_t         gear_out_q[$];
    cfg_t                 gearing;
    logic [1:0]           enc_phase;
    logic                 direction;
    logic [ACC_WIDTH-1:0] accumulator;
    logic [31:0]          lead_count;
    logic [31:0]          spindle_count;
    logic                 drive_en;
    int                   fails;

    // quadrature transitions, index {old b, old a, new b, new a}
    function automatic logic [1:0] classify_edge(logic [1:0] old_ph, logic [1:0] new_ph);
        case ({old_ph, new_ph})
            4'b0010, 4'b1011, 4'b1101, 4'b0100: return EDGE_FWD;
            4'b0001, 4'b0111, 4'b1110, 4'b1000: return EDGE_REV;
            4'b0011, 4'b0110, 4'b1001, 4'b1100: return EDGE_BAD;
            default:                            return EDGE_NONE;
        endcase
    endfunction

    task automatic record_result(logic is_step);
        gear_result_t r;
        r.has_step           = is_step;
        r.step_direction     = direction;
        r.leadscrew_position = lead_count;
        r.spindle_position   = spindle_count;
        r.enabled_now        = drive_en;
        r.last               = 1'b0;
        gear_out_q.push_back(r);
    endtask

    task automatic turn_gearbox(logic [CMD_WIDTH-1:0] cmd, logic a, logic b, logic en);
        int                   steps;
        logic [1:0]           new_ph;
        logic [1:0]           code;
        logic [ACC_WIDTH-1:0] den_eff;
        gear_result_t         tail;
        steps = 0;
        case (cmd)
            CMD_SAMPLE:
            begin
                new_ph    = {b, a};
                code      = classify_edge(enc_phase, new_ph);
                enc_phase = new_ph;
                if (code == EDGE_FWD || code == EDGE_REV)
                begin
                    direction = (code == EDGE_FWD);
                    if (drive_en)
                    begin
                        den_eff = (gearing.ratio_denominator == '0) ? ACC_WIDTH'(1)
                                : ACC_WIDTH'(gearing.ratio_denominator);
                        accumulator = accumulator + ACC_WIDTH'(gearing.ratio_numerator);
                        while (accumulator >= den_eff && steps < MAX_STEPS)
                        begin
                            accumulator = accumulator - den_eff;
                            lead_count  = direction ? lead_count + 1 : lead_count - 1;
                            if (gearing.stop_at_zero && lead_count == 0)
                                drive_en = 1'b0;
                            record_result(1'b1);
                            steps++;
                        end
                    end
                    else if (gearing.thread_mode)
                    begin
                        spindle_count = direction ? spindle_count + 1 : spindle_count - 1;
                    end
                end
            end
            CMD_ENABLE: drive_en = en;
            CMD_ZERO:
            begin
                lead_count    = '0;
                spindle_count = 32'd1;
            end
            default: ;
        endcase
        if (steps == 0)
            record_result(1'b0);
        tail      = gear_out_q.pop_back();
        tail.last = 1'b1;
        gear_out_q.push_back(tail);
    endtask

    task automatic check_result;
        gear_result_t seen;
        gear_result_t want;
        seen.has_step           = result_ch.has_step;
        seen.step_direction     = result_ch.step_direction;
        seen.leadscrew_position = result_ch.leadscrew_position;
        seen.spindle_position   = result_ch.spindle_position;
        seen.enabled_now        = result_ch.enabled_now;
        seen.last               = result_ch.last;
        if (gear_out_q.size() == 0)
        begin
            if (fails < 10)
                $display("unexpected result transaction: step=%0d lead=%0d spin=%0d",
                         seen.has_step, $signed(seen.leadscrew_position),
                         $signed(seen.spindle_position));
            fails++;
        end
        else
        begin
            want = gear_out_q.pop_front();
            if (seen !== want)
            begin
                if (fails < 10)
                begin
                    $display("mismatch expected step=%0d dir=%0d lead=%0d spin=%0d en=%0d last=%0d",
                             want.has_step, want.step_direction,
                             $signed(want.leadscrew_position),
                             $signed(want.spindle_position), want.enabled_now, want.last);
                    $display("         got step=%0d dir=%0d lead=%0d spin=%0d en=%0d last=%0d",
                             seen.has_step, seen.step_direction,
                             $signed(seen.leadscrew_position),
                             $signed(seen.spindle_position), seen.enabled_now, seen.last);
                end
                fails++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            gearing.ratio_numerator   = NUM_WIDTH'(1);
            gearing.ratio_denominator = DEN_WIDTH'(1);
            gearing.thread_mode       = 1'b1;
            gearing.stop_at_zero      = 1'b0;
            enc_phase     = 2'b00;
            direction     = 1'b0;
            accumulator   = '0;
            lead_count    = '0;
            spindle_count = 32'd1;
            drive_en      = 1'b0;
            fails         = 0;
            gear_out_q.delete();
        end
        else
        begin
            // results come from earlier inputs, so check before predicting
            if (result_ch.valid && result_ch.ready)
                check_result();
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[qrsg_pkg::APB_ADDR_WIDTH-1:2])
                    REG_RATIO_NUM: gearing.ratio_numerator   = pwdata[NUM_WIDTH-1:0];
                    REG_RATIO_DEN: gearing.ratio_denominator = pwdata[DEN_WIDTH-1:0];
                    REG_THREAD:    gearing.thread_mode       = pwdata[0];
                    REG_STOP_ZERO: gearing.stop_at_zero      = pwdata[0];
                    default: ;
                endcase
            end
            if (cmd_ch.valid && cmd_ch.ready)
                turn_gearbox(cmd_ch.command, cmd_ch.phase_a, cmd_ch.phase_b,
                             cmd_ch.enable_value);
        end
        fail_count <= fails;
        pending    <= gear_out_q.size();
    end

endmodule

@@ bench/quadrature_ratio_step_generator_tb.sv @@
`timescale 1ns / 1ps

module quadrature_ratio_step_generator_tb;
    import qrsg_pkg::*;

    // command code the block leaves unused, still legal on the wire
    localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

    localparam int HOLD_CYCLES     = 300;    // long receiver hold-off
    localparam int STALL_LIMIT     = 3000;   // cycles without any transaction
    localparam int SETTLE_CYCLES   = 16;     // quiet time after the last result
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 29;

    logic clk = 1'b0;
    logic rst_n;

    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    int fail_count;
    int pending;

    // traffic shaping, written by the stimulus process
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_requests;

    // encoder levels last sent and the direction of the current run
    logic [1:0] quad_phase;
    logic       run_forward;

    qrsg_in_if  cmd_ch ();
    qrsg_out_if result_ch ();

    quadrature_ratio_step_generator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (cmd_ch),
        .out_ch  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    qrsg_checker gear_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_ch     (cmd_ch),
        .result_ch  (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int held;
        int hold_left;
        held      = 0;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (held != hold_requests)
            begin
                held++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // watchdog: gives up when the channels stay silent too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // one input transaction, held until taken, then a random idle gap
    task automatic send_item(logic [CMD_WIDTH-1:0] cmd, logic a, logic b, logic en);
        int gap;
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= cmd;
        cmd_ch.phase_a      <= a;
        cmd_ch.phase_b      <= b;
        cmd_ch.enable_value <= en;
        if (cmd == CMD_SAMPLE)
            quad_phase = {b, a};
        do @(posedge clk); while (!cmd_ch.ready);
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_sample(logic a, logic b);
        send_item(CMD_SAMPLE, a, b, 1'($urandom_range(1)));
    endtask

    task automatic send_command(logic [CMD_WIDTH-1:0] cmd, logic en);
        send_item(cmd, 1'($urandom_range(1)), 1'($urandom_range(1)), en);
    endtask

    // legal quadrature move, levels as {b, a}
    task automatic step_encoder(logic fwd);
        logic [1:0] next_ph;
        case (quad_phase)
            2'b00:   next_ph = fwd ? 2'b10 : 2'b01;
            2'b10:   next_ph = fwd ? 2'b11 : 2'b00;
            2'b11:   next_ph = fwd ? 2'b01 : 2'b10;
            default: next_ph = fwd ? 2'b00 : 2'b11;
        endcase
        send_sample(next_ph[0], next_ph[1]);
    endtask

    // apb write, back to back with the next one; psel stays up
    task automatic write_reg(logic [REG_IDX_WIDTH-1:0] idx, logic [APB_DATA_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic set_gearing(logic [NUM_WIDTH-1:0] num, logic [DEN_WIDTH-1:0] den,
                               logic thread, logic stopz);
        write_reg(REG_RATIO_NUM, APB_DATA_WIDTH'(num));
        write_reg(REG_RATIO_DEN, APB_DATA_WIDTH'(den));
        write_reg(REG_THREAD, APB_DATA_WIDTH'(thread));
        write_reg(REG_STOP_ZERO, APB_DATA_WIDTH'(stopz));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop offering and wait until every expected result is taken
    task automatic drain;
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // mostly clean quadrature runs with the drive on, some noise and commands
    task automatic random_item;
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            if ($urandom_range(9) == 0)
                run_forward = !run_forward;
            step_encoder(run_forward);
        end
        else if (pick < 75)
            send_sample(quad_phase[0], quad_phase[1]);     // no movement
        else if (pick < 79)
            send_sample(!quad_phase[0], !quad_phase[1]);   // skipped state
        else if (pick < 90)
            send_command(CMD_ENABLE, $urandom_range(3) != 0);
        else if (pick < 96)
            send_command(CMD_ZERO, 1'($urandom_range(1)));
        else
            send_command(CMD_UNUSED, 1'($urandom_range(1)));
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.command      = CMD_SAMPLE;
        cmd_ch.phase_a      = 1'b0;
        cmd_ch.phase_b      = 1'b0;
        cmd_ch.enable_value = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        quad_phase          = 2'b00;
        run_forward         = 1'b1;
        tx_idle_pct         = 0;
        rx_stall_pct        = 0;
        hold_requests       = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: thread mode with the drive off tracks the spindle
        set_gearing(6'd1, 8'd1, 1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        step_encoder(1'b0);
        step_encoder(1'b0);
        send_sample(!quad_phase[0], !quad_phase[1]);
        step_encoder(1'b1);
        step_encoder(1'b1);
        // drive on: one step per edge, direction follows the edge
        send_command(CMD_ENABLE, 1'b1);
        step_encoder(1'b1);
        step_encoder(1'b1);
        step_encoder(1'b0);
        send_command(CMD_ZERO, 1'b0);
        send_item(CMD_UNUSED, 1'b1, 1'b1, 1'b1);
        send_command(CMD_ENABLE, 1'b0);
        step_encoder(1'b1);
        drain();

        // burst of five backward steps
        set_gearing(6'd5, 8'd1, 1'b0, 1'b0);
        send_command(CMD_ENABLE, 1'b1);
        step_encoder(1'b0);
        drain();

        // full 63 step burst crosses zero: drive drops, burst goes on
        set_gearing(6'd63, 8'd1, 1'b0, 1'b1);
        step_encoder(1'b1);
        step_encoder(1'b1);                 // feed mode, drive off: ignored
        drain();

        // widest ratio: accumulate over several edges before a step
        set_gearing(6'd63, 8'd255, 1'b1, 1'b0);
        send_command(CMD_ENABLE, 1'b1);
        repeat (5) step_encoder(1'b1);
        drain();

        // zero numerator and zero denominator pay out the leftover
        set_gearing(6'd0, 8'd0, 1'b1, 1'b0);
        step_encoder(1'b1);
        step_encoder(1'b0);
        drain();

        // random phases, each with its own gearing and traffic pattern
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: set_gearing(6'd63, 8'd1, 1'b1, 1'b0);
                1: set_gearing(6'd1, 8'd255, 1'b1, 1'b1);
                2: set_gearing(6'd63, 8'd255, 1'b0, 1'b1);
                3: set_gearing(6'd1, 8'd1, 1'b0, 1'b0);
                default: set_gearing(NUM_WIDTH'($urandom_range(63, 1)),
                                     ($urandom_range(1) != 0) ? DEN_WIDTH'($urandom_range(8, 1))
                                                              : DEN_WIDTH'($urandom_range(255, 1)),
                                     1'($urandom_range(1)), 1'($urandom_range(1)));
            endcase
            case (p % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 76;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 76;
                end
                default:
                begin
                    tx_idle_pct  = 10;
                    rx_stall_pct = 10;
                end
            endcase
            send_command(CMD_ENABLE, 1'b1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // receiver holds off while inputs keep coming, so the block backs up
                if (p == 0 && i == 8)
                    hold_requests++;
                // sender waits for the block to run dry before going on
                if (p == 0 && i == 18)
                    drain();
                random_item();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ quadrature_ratio_step_generator.f @@
design/qrsg_pkg.sv
design/qrsg_if.sv
design/qrsg_cfg.sv
design/qrsg_acc_unit.sv
design/qrsg_seq.sv
design/quadrature_ratio_step_generator.sv
bench/qrsg_checker.sv
bench/quadrature_ratio_step_generator_tb.sv
